FILE: hdl/sdf_pkg.sv
package sdf_pkg;

    // Field widths
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int DIST_BITS   = COORD_BITS + 2;

    // Datapath widths
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int MAG_BITS  = COORD_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;

    // Square root pipeline: a few restoring steps per register stage
    localparam int ITERS_PER_STAGE = 3;
    localparam int SQRT_STAGES     = (ROOT_BITS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    localparam int SQRT_ITERS      = SQRT_STAGES * ITERS_PER_STAGE;
    localparam int RADICAND_BITS   = 2 * SQRT_ITERS;
    localparam int REM_BITS        = SQRT_ITERS + 3;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [REM_BITS-1:0]      rem;
        logic [SQRT_ITERS-1:0]    root;
        logic [RADICAND_BITS-1:0] rad;
    } sqrt_state_t;

    // One restoring square root step: bring down the next bit pair, try 4q+1.
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st);
        logic [REM_BITS-1:0] cur;
        logic [REM_BITS-1:0] trial;
        sqrt_state_t         nxt;
        cur   = {st.rem[REM_BITS-3:0], st.rad[RADICAND_BITS-1 -: 2]};
        trial = REM_BITS'({st.root, 2'b01});
        nxt.rad = {st.rad[RADICAND_BITS-3:0], 2'b00};
        if (cur >= trial) begin
            nxt.rem  = cur - trial;
            nxt.root = {st.root[SQRT_ITERS-2:0], 1'b1};
        end else begin
            nxt.rem  = cur;
            nxt.root = {st.root[SQRT_ITERS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic sqrt_state_t sqrt_stage(input sqrt_state_t st);
        sqrt_state_t tmp;
        tmp = st;
        for (int i = 0; i < ITERS_PER_STAGE; i++) begin
            tmp = sqrt_step(tmp);
        end
        return tmp;
    endfunction

endpackage

FILE: hdl/sdf_sq_pipe.sv
module sdf_sq_pipe (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    point_x,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    point_y,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    point_z,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    center_x,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    center_y,
    input  logic signed [sdf_pkg::COORD_BITS-1:0]    center_z,
    output logic                                     out_valid,
    output logic [sdf_pkg::SUM_BITS-1:0]             sum
);

    localparam int DB = sdf_pkg::DIFF_BITS;
    localparam int MB = sdf_pkg::MAG_BITS;
    localparam int QB = sdf_pkg::SQ_BITS;
    localparam int SB = sdf_pkg::SUM_BITS;

    logic signed [DB-1:0] dx, dy, dz;
    logic [DB-1:0]        ax, ay, az;

    logic [MB-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [QB-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SB-1:0] sum_reg;
    logic          v1_reg, v2_reg, v3_reg;

    assign dx = DB'(point_x) - DB'(center_x);
    assign dy = DB'(point_y) - DB'(center_y);
    assign dz = DB'(point_z) - DB'(center_z);

    assign ax = dx[DB-1] ? DB'(-dx) : DB'(dx);
    assign ay = dy[DB-1] ? DB'(-dy) : DB'(dy);
    assign az = dz[DB-1] ? DB'(-dz) : DB'(dz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // magnitude of a difference of two COORD_BITS-bit values fits in MB bits
            mag_x_reg <= ax[MB-1:0];
            mag_y_reg <= ay[MB-1:0];
            mag_z_reg <= az[MB-1:0];
            sq_x_reg  <= QB'(mag_x_reg) * QB'(mag_x_reg);
            sq_y_reg  <= QB'(mag_y_reg) * QB'(mag_y_reg);
            sq_z_reg  <= QB'(mag_z_reg) * QB'(mag_z_reg);
            sum_reg   <= SB'(sq_x_reg) + SB'(sq_y_reg) + SB'(sq_z_reg);
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;

endmodule

FILE: hdl/sdf_sqrt_pipe.sv
module sdf_sqrt_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [sdf_pkg::SUM_BITS-1:0]  radicand,
    output logic                          out_valid,
    output logic [sdf_pkg::ROOT_BITS-1:0] root
);

    localparam int NS = sdf_pkg::SQRT_STAGES;

    sdf_pkg::sqrt_state_t stage_in   [NS];
    sdf_pkg::sqrt_state_t stage_next [NS];
    sdf_pkg::sqrt_state_t st_reg     [NS];
    logic [NS-1:0]        vld_reg;

    assign stage_in[0].rem  = '0;
    assign stage_in[0].root = '0;
    assign stage_in[0].rad  = sdf_pkg::RADICAND_BITS'(radicand);

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s > 0) begin : g_link
            assign stage_in[s] = st_reg[s-1];
        end

        assign stage_next[s] = sdf_pkg::sqrt_stage(stage_in[s]);

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[s] <= stage_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign root      = st_reg[NS-1].root[sdf_pkg::ROOT_BITS-1:0];

endmodule

FILE: hdl/sphere_signed_distance.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_point_x, s_point_y, s_point_z (Q8.8)
// m_        out        m_valid / m_ready  m_signed_distance (Q10.8), m_inside_res
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One point per cycle unless m_ stalls; three stages for difference, square
// and sum, six for the square root (three restoring steps each), one output stage.
// Reset (synchronous, aresetn low) clears all valid bits and loads the registers
// with centre 0 and radius 1.0.
// A result waiting at m_ holds the whole pipeline; s_ready follows that stall.
module sphere_signed_distance (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [sdf_pkg::COORD_BITS-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sdf_pkg::COORD_BITS-1:0] s_point_x,
    input  logic signed [sdf_pkg::COORD_BITS-1:0] s_point_y,
    input  logic signed [sdf_pkg::COORD_BITS-1:0] s_point_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sdf_pkg::DIST_BITS-1:0]  m_signed_distance,
    output logic                                  m_inside_res
);

    localparam int CB = sdf_pkg::COORD_BITS;
    localparam int RB = sdf_pkg::RADIUS_BITS;
    localparam int DB = sdf_pkg::DIST_BITS;

    logic signed [CB-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [RB-1:0]        radius_reg;

    logic                          en;
    logic                          sum_valid;
    logic [sdf_pkg::SUM_BITS-1:0]  sum;
    logic                          root_valid;
    logic [sdf_pkg::ROOT_BITS-1:0] root;
    logic [DB-1:0]                 surface_dist;

    logic                 m_valid_reg;
    logic signed [DB-1:0] m_signed_distance_reg;
    logic                 m_inside_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= sdf_pkg::RADIUS_RESET;
        end else if (cfg_wr_en) begin
            case (sdf_pkg::reg_index_t'(cfg_index))
                sdf_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata;
                sdf_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata;
                sdf_pkg::REG_CENTER_Z: center_z_reg <= cfg_wdata;
                sdf_pkg::REG_RADIUS:   radius_reg   <= cfg_wdata[RB-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless a result is stuck at the output
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    sdf_sq_pipe u_sq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .point_z   (s_point_z),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .out_valid (sum_valid),
        .sum       (sum)
    );

    sdf_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sum_valid),
        .radicand  (sum),
        .out_valid (root_valid),
        .root      (root)
    );

    assign surface_dist = DB'(root) - DB'(radius_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_signed_distance_reg <= surface_dist;
            m_inside_res_reg      <= surface_dist[DB-1];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_signed_distance = m_signed_distance_reg;
    assign m_inside_res      = m_inside_res_reg;

endmodule

FILE: bench/tb_sphere_signed_distance.sv
`timescale 1ns / 100ps

module tb_sphere_signed_distance;

    typedef struct packed {
        logic signed [sdf_pkg::DIST_BITS-1:0] distance;
        logic                                 inside_flag;
    } sdf_result_t;

    typedef enum bit {
        ROW_POINT,
        ROW_WRITE
    } row_kind_t;

    // A write row carries its value in x.
    typedef struct packed {
        row_kind_t                             kind;
        sdf_pkg::reg_index_t                   idx;
        logic signed [sdf_pkg::COORD_BITS-1:0] x;
        logic signed [sdf_pkg::COORD_BITS-1:0] y;
        logic signed [sdf_pkg::COORD_BITS-1:0] z;
        bit                                    preset;
        logic signed [sdf_pkg::DIST_BITS-1:0]  distance;
        logic                                  inside_flag;
    } dir_row_t;

    logic                                  aclk;
    logic                                  aresetn     = 1'b0;
    logic                                  cfg_wr_en   = 1'b0;
    sdf_pkg::reg_index_t                   cfg_index   = sdf_pkg::REG_CENTER_X;
    logic [sdf_pkg::COORD_BITS-1:0]        cfg_wdata   = '0;
    logic                                  s_valid     = 1'b0;
    logic                                  s_ready;
    logic signed [sdf_pkg::COORD_BITS-1:0] s_point_x   = '0;
    logic signed [sdf_pkg::COORD_BITS-1:0] s_point_y   = '0;
    logic signed [sdf_pkg::COORD_BITS-1:0] s_point_z   = '0;
    logic                                  m_valid;
    logic                                  m_ready     = 1'b0;
    logic signed [sdf_pkg::DIST_BITS-1:0]  m_signed_distance;
    logic                                  m_inside_res;

    logic signed [sdf_pkg::COORD_BITS-1:0] ctr_x      = '0;
    logic signed [sdf_pkg::COORD_BITS-1:0] ctr_y      = '0;
    logic signed [sdf_pkg::COORD_BITS-1:0] ctr_z      = '0;
    logic [sdf_pkg::RADIUS_BITS-1:0]       radius_cfg = sdf_pkg::RADIUS_RESET;

    sdf_result_t awaited_distances[$];
    dir_row_t    dir_rows[32];
    bit          steady_flow = 1'b0;
    int          error_count = 0;

    sphere_signed_distance i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_point_z         (s_point_z),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_signed_distance (m_signed_distance),
        .m_inside_res      (m_inside_res)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic sdf_result_t sphere_distance(
            input logic signed [sdf_pkg::COORD_BITS-1:0] px,
            input logic signed [sdf_pkg::COORD_BITS-1:0] py,
            input logic signed [sdf_pkg::COORD_BITS-1:0] pz);
        longint      dx;
        longint      dy;
        longint      dz;
        longint      sum_sq;
        longint      len;
        longint      diff;
        sdf_result_t res;
        dx     = longint'(px) - longint'(ctr_x);
        dy     = longint'(py) - longint'(ctr_y);
        dz     = longint'(pz) - longint'(ctr_z);
        sum_sq = dx * dx + dy * dy + dz * dz;
        // Settle the real root onto the exact floor.
        len = longint'($sqrt(real'(sum_sq)));
        while (len * len > sum_sq) len--;
        while ((len + 1) * (len + 1) <= sum_sq) len++;
        diff            = len - longint'(radius_cfg);
        res.distance    = sdf_pkg::DIST_BITS'(diff);
        res.inside_flag = (diff < 0);
        return res;
    endfunction

    task automatic write_reg(input sdf_pkg::reg_index_t idx,
                             input logic [sdf_pkg::COORD_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            sdf_pkg::REG_CENTER_X: ctr_x = val;
            sdf_pkg::REG_CENTER_Y: ctr_y = val;
            sdf_pkg::REG_CENTER_Z: ctr_z = val;
            sdf_pkg::REG_RADIUS:   radius_cfg = val[sdf_pkg::RADIUS_BITS-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic offer_point(input logic signed [sdf_pkg::COORD_BITS-1:0] px,
                               input logic signed [sdf_pkg::COORD_BITS-1:0] py,
                               input logic signed [sdf_pkg::COORD_BITS-1:0] pz,
                               input bit preset, input sdf_result_t preset_res);
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        cfg_wr_en <= 1'b0;
        do @(posedge aclk); while (!s_ready);
        awaited_distances.insert(awaited_distances.size(),
                                 preset ? preset_res : sphere_distance(px, py, pz));
        if (!steady_flow && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Every point yields a result, so an empty queue means the pipeline is empty.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_distances.size() != 0);
    endtask

    initial begin : stimulus
        sdf_result_t                           preset_res;
        logic signed [sdf_pkg::COORD_BITS-1:0] px;
        logic signed [sdf_pkg::COORD_BITS-1:0] py;
        logic signed [sdf_pkg::COORD_BITS-1:0] pz;
        logic signed [sdf_pkg::COORD_BITS-1:0] corner[4];
        logic [sdf_pkg::COORD_BITS-1:0]        cx;
        logic [sdf_pkg::COORD_BITS-1:0]        cy;
        logic [sdf_pkg::COORD_BITS-1:0]        cz;
        logic [sdf_pkg::COORD_BITS-1:0]        rw;
        int                                    span;
        int                                    off;
        int                                    pick;
        bit                                    prev_write;

        dir_rows = '{
            // reset setting: centre at origin, radius 1.0
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd0, 16'sd0, 16'sd0, 1'b1, -18'sd256, 1'b1},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd256, 16'sd0, 16'sd0, 1'b1, 18'sd0, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd0, -16'sd255, 16'sd0, 1'b1, -18'sd1, 1'b1},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd0, 16'sd0, 16'sd257, 1'b1, 18'sd1, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 18'sd32512,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd0, 16'sh7FFF, 16'sd0, 1'b1, 18'sd32511,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd181, 16'sd181, 16'sd0, 1'b0, 18'sd0, 1'b0},
            // zero radius, off-origin centre
            '{ROW_WRITE, sdf_pkg::REG_CENTER_X, 16'sd1000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Y, -16'sd2000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Z, 16'sd500, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_RADIUS, 16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd1000, -16'sd2000, 16'sd500, 1'b1, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd1768, -16'sd2000, 16'sd500, 1'b1, 18'sd768,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd1000, -16'sd2000, 16'sh8000, 1'b0, 18'sd0,
              1'b0},
            // top bit of the radius write is dropped
            '{ROW_WRITE, sdf_pkg::REG_RADIUS, 16'shFFFF, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd1000, -16'sd2000, 16'sd500, 1'b1,
              -18'sd32767, 1'b1},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sd1000, 16'sd30767, 16'sd500, 1'b1, 18'sd0,
              1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Y, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Z, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_RADIUS, 16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sd0, 16'sh8000, 1'b1, 18'sd32768,
              1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_X, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Y, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_CENTER_Z, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_WRITE, sdf_pkg::REG_RADIUS, 16'sd256, 16'sd0, 16'sd0, 1'b0, 18'sd0, 1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 18'sd0,
              1'b0},
            '{ROW_POINT, sdf_pkg::REG_CENTER_X, 16'sh7FFF, 16'sh7FFF, 16'sd32511, 1'b1, 18'sd0,
              1'b0}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        prev_write = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                if (!prev_write) wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].x);
            end else begin
                preset_res = '{dir_rows[i].distance, dir_rows[i].inside_flag};
                offer_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                            dir_rows[i].preset, preset_res);
            end
            prev_write = (dir_rows[i].kind == ROW_WRITE);
        end

        preset_res = '0;
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            steady_flow <= (ph == 3);
            case (ph)
                0: begin
                    cx = sdf_pkg::COORD_BITS'($urandom);
                    cy = sdf_pkg::COORD_BITS'($urandom);
                    cz = sdf_pkg::COORD_BITS'($urandom);
                    rw = sdf_pkg::COORD_BITS'($urandom_range(0, 32767));
                end
                1: begin
                    cx = 16'h8000;
                    cy = 16'h8000;
                    cz = 16'h8000;
                    rw = 16'hFFFF;
                end
                2: begin
                    cx = 16'h7FFF;
                    cy = 16'h7FFF;
                    cz = 16'h7FFF;
                    rw = 16'h0000;
                end
                3: begin
                    cx = sdf_pkg::COORD_BITS'($urandom_range(0, 4095) - 2048);
                    cy = sdf_pkg::COORD_BITS'($urandom_range(0, 4095) - 2048);
                    cz = sdf_pkg::COORD_BITS'($urandom_range(0, 4095) - 2048);
                    rw = sdf_pkg::COORD_BITS'($urandom_range(0, 2048));
                end
                default: begin
                    cx = sdf_pkg::COORD_BITS'($urandom);
                    cy = sdf_pkg::COORD_BITS'($urandom);
                    cz = sdf_pkg::COORD_BITS'($urandom);
                    rw = sdf_pkg::COORD_BITS'($urandom);
                end
            endcase
            write_reg(sdf_pkg::REG_CENTER_X, cx);
            write_reg(sdf_pkg::REG_CENTER_Y, cy);
            write_reg(sdf_pkg::REG_CENTER_Z, cz);
            write_reg(sdf_pkg::REG_RADIUS, rw);

            for (int n = 0; n < 256; n++) begin
                pick = $urandom_range(0, 9);
                span = int'(radius_cfg) + 32;
                if (pick < 4) begin
                    px = sdf_pkg::COORD_BITS'($urandom);
                    py = sdf_pkg::COORD_BITS'($urandom);
                    pz = sdf_pkg::COORD_BITS'($urandom);
                end else if (pick < 8) begin
                    // cube around the sphere: up to about half the points land inside
                    px = sdf_pkg::COORD_BITS'(int'(ctr_x) + int'($urandom_range(0, 2 * span))
                                              - span);
                    py = sdf_pkg::COORD_BITS'(int'(ctr_y) + int'($urandom_range(0, 2 * span))
                                              - span);
                    pz = sdf_pkg::COORD_BITS'(int'(ctr_z) + int'($urandom_range(0, 2 * span))
                                              - span);
                end else if (pick == 8) begin
                    // on the surface along one axis, or one LSB inside it
                    px  = ctr_x;
                    py  = ctr_y;
                    pz  = ctr_z;
                    off = int'(radius_cfg) - int'($urandom_range(0, 1));
                    if ($urandom_range(0, 1) == 1) off = -off;
                    case ($urandom_range(0, 2))
                        0:       px = sdf_pkg::COORD_BITS'(int'(ctr_x) + off);
                        1:       py = sdf_pkg::COORD_BITS'(int'(ctr_y) + off);
                        default: pz = sdf_pkg::COORD_BITS'(int'(ctr_z) + off);
                    endcase
                end else begin
                    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, ctr_x};
                    px = corner[$urandom_range(0, 3)];
                    corner[3] = ctr_y;
                    py = corner[$urandom_range(0, 3)];
                    corner[3] = ctr_z;
                    pz = corner[$urandom_range(0, 3)];
                end
                offer_point(px, py, pz, 1'b0, preset_res);
            end
        end

        s_valid <= 1'b0;
        while (awaited_distances.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : result_sink
        sdf_result_t want;
        int          taken;
        bit          held_off;
        taken    = 0;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                if (awaited_distances.size() == 0) begin
                    $error("unexpected result: signed_distance %0d, inside_res %0b",
                           m_signed_distance, m_inside_res);
                    error_count++;
                end else begin
                    want = awaited_distances.pop_front();
                    if (m_signed_distance !== want.distance) begin
                        $error("signed_distance: expected %0d, got %0d",
                               want.distance, m_signed_distance);
                        error_count++;
                    end
                    if (m_inside_res !== want.inside_flag) begin
                        $error("inside_res: expected %0b, got %0b",
                               want.inside_flag, m_inside_res);
                        error_count++;
                    end
                end
            end
            // Hold off once so the pipeline backs up into the input.
            if (!held_off && taken >= 400) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= steady_flow || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sphere_signed_distance.f
hdl/sdf_pkg.sv
hdl/sdf_sq_pipe.sv
hdl/sdf_sqrt_pipe.sv
hdl/sphere_signed_distance.sv
bench/tb_sphere_signed_distance.sv
